FILE: hdl/vpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_pkg
// Shared constants, micro-op type and the fixed projection program.
// ----------------------------------------------------------------------------
package vpw_pkg;

	localparam int VPW_FRAC_BITS = 16;
	localparam int VPW_WORD_BITS = 32;

	localparam int REG_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;

	localparam int COEF_DEPTH = 32;
	localparam int SCR_DEPTH  = 16;

	// operand sources
	localparam logic [3:0] SRC_COEF  = 4'd0;
	localparam logic [3:0] SRC_SCR   = 4'd1;
	localparam logic [3:0] SRC_PX    = 4'd2;
	localparam logic [3:0] SRC_PY    = 4'd3;
	localparam logic [3:0] SRC_PZ    = 4'd4;
	localparam logic [3:0] SRC_RW    = 4'd5;
	localparam logic [3:0] SRC_HALF  = 4'd6;
	localparam logic [3:0] SRC_NHALF = 4'd7;
	localparam logic [3:0] SRC_ONE   = 4'd8;
	localparam logic [3:0] SRC_PIXW  = 4'd9;
	localparam logic [3:0] SRC_PIXH  = 4'd10;
	localparam logic [3:0] SRC_PIXOX = 4'd11;
	localparam logic [3:0] SRC_PIXOY = 4'd12;

	// scratch slots
	localparam logic [3:0] SCR_E0 = 4'd0;
	localparam logic [3:0] SCR_E2 = 4'd2;
	localparam logic [3:0] SCR_C0 = 4'd4;
	localparam logic [3:0] SCR_C1 = 4'd5;
	localparam logic [3:0] SCR_C2 = 4'd6;
	localparam logic [3:0] SCR_N0 = 4'd7;
	localparam logic [3:0] SCR_N1 = 4'd8;
	localparam logic [3:0] SCR_N2 = 4'd9;
	localparam logic [3:0] SCR_T  = 4'd10;
	localparam logic [3:0] SCR_WX = 4'd11;
	localparam logic [3:0] SCR_WY = 4'd12;
	localparam logic [3:0] SCR_WD = 4'd13;

	localparam int PC_W      = 6;
	localparam logic [PC_W-1:0] PC_DIV = 6'd28;
	localparam logic [PC_W-1:0] PC_END = 6'd42;

	typedef struct packed {
		logic [3:0] src_a;
		logic [3:0] src_b;
		logic [4:0] caddr;
		logic [3:0] saddr;
		logic       is_add;
		logic       first;
		logic       last;
		logic [3:0] dest;
	} uop_t;

	function automatic uop_t mk(input logic [3:0] a, input logic [3:0] b,
			input logic [4:0] ca, input logic [3:0] sa, input logic ad,
			input logic f, input logic l, input logic [3:0] d);
		uop_t u;
		u.src_a = a; u.src_b = b; u.caddr = ca; u.saddr = sa;
		u.is_add = ad; u.first = f; u.last = l; u.dest = d;
		return u;
	endfunction

	function automatic uop_t vpw_prog(input logic [PC_W-1:0] pc);
		uop_t u;
		logic [1:0] r;
		logic [1:0] k;
		logic [3:0] i;
		logic [3:0] pt;
		r  = pc[3:2];
		k  = pc[1:0];
		i  = 4'(pc - 6'd16);
		pt = SRC_PX;
		if (pc < 6'd16) begin
			case (k)
				2'd0: pt = SRC_PX;
				2'd1: pt = SRC_PY;
				2'd2: pt = SRC_PZ;
				default: pt = SRC_PX;
			endcase
			if (k == 2'd3)
				u = mk(SRC_COEF, SRC_COEF, 5'd12 + 5'(r), SCR_E0, 1'b1, 1'b0, 1'b1,
					SCR_E0 + 4'(r));
			else
				u = mk(SRC_COEF, pt, 5'(r) + {k, 2'b00}, SCR_E0, 1'b0, k == 2'd0,
					1'b0, SCR_E0);
		end else if (pc < PC_DIV) begin
			u = mk(SRC_COEF, SRC_SCR, 5'd16 + 5'(i[3:2]) + {1'b0, i[1:0], 2'b00},
				SCR_E0 + 4'(i[1:0]), 1'b0, i[1:0] == 2'd0, i[1:0] == 2'd3,
				SCR_C0 + 4'(i[3:2]));
		end else begin
			case (pc)
				6'd28: u = mk(SRC_SCR, SRC_RW, 5'd0, SCR_C0, 1'b0, 1'b1, 1'b1, SCR_N0);
				6'd29: u = mk(SRC_SCR, SRC_RW, 5'd0, SCR_C1, 1'b0, 1'b1, 1'b1, SCR_N1);
				6'd30: u = mk(SRC_SCR, SRC_RW, 5'd0, SCR_C2, 1'b0, 1'b1, 1'b1, SCR_N2);
				6'd31: u = mk(SRC_SCR, SRC_HALF, 5'd0, SCR_N0, 1'b0, 1'b1, 1'b0, SCR_T);
				6'd32: u = mk(SRC_HALF, SRC_HALF, 5'd0, SCR_T, 1'b1, 1'b0, 1'b1, SCR_T);
				6'd33: u = mk(SRC_SCR, SRC_PIXW, 5'd0, SCR_T, 1'b0, 1'b1, 1'b0, SCR_WX);
				6'd34: u = mk(SRC_PIXOX, SRC_PIXOX, 5'd0, SCR_T, 1'b1, 1'b0, 1'b1, SCR_WX);
				6'd35: u = mk(SRC_SCR, SRC_NHALF, 5'd0, SCR_N1, 1'b0, 1'b1, 1'b0, SCR_T);
				6'd36: u = mk(SRC_HALF, SRC_HALF, 5'd0, SCR_T, 1'b1, 1'b0, 1'b1, SCR_T);
				6'd37: u = mk(SRC_SCR, SRC_PIXH, 5'd0, SCR_T, 1'b0, 1'b1, 1'b0, SCR_WY);
				6'd38: u = mk(SRC_PIXOY, SRC_PIXOY, 5'd0, SCR_T, 1'b1, 1'b0, 1'b1, SCR_WY);
				6'd39: u = mk(SRC_ONE, SRC_ONE, 5'd0, SCR_N2, 1'b1, 1'b1, 1'b0, SCR_T);
				6'd40: u = mk(SRC_SCR, SRC_SCR, 5'd0, SCR_N2, 1'b1, 1'b0, 1'b1, SCR_T);
				6'd41: u = mk(SRC_SCR, SRC_HALF, 5'd0, SCR_T, 1'b0, 1'b1, 1'b1, SCR_WD);
				default: u = mk(SRC_ONE, SRC_ONE, 5'd0, SCR_T, 1'b1, 1'b1, 1'b1, SCR_T);
			endcase
		end
		return u;
	endfunction

endpackage

FILE: hdl/vpw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/vpw_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_mul
// Fixed-point multiply: four half-width partial products accumulated in turn,
// then round to nearest (ties away from zero) and saturate.
// ----------------------------------------------------------------------------
module vpw_mul import vpw_pkg::*; #(
	parameter int WORD_BITS = VPW_WORD_BITS,
	parameter int FRAC_BITS = VPW_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] prod
);

	localparam int H  = (WORD_BITS + 1) / 2;
	localparam int MW = 2 * H;
	localparam int PW = 4 * H;

	logic [MW-1:0] am_q, bm_q;
	logic          neg_q;
	logic [PW-1:0] acc_q;
	logic [1:0]    cnt_q;
	logic          busy_q, rnd_q, done_q;
	logic signed [WORD_BITS-1:0] res_q;

	logic [MW-1:0] ae, be;
	logic [H-1:0]  ah, bh;
	logic [PW-1:0] pp, rnd, mag, lim, smag;

	always_comb begin
		ae = MW'(a);
		be = MW'(b);
		ah = cnt_q[0] ? am_q[MW-1:H] : am_q[H-1:0];
		bh = cnt_q[1] ? bm_q[MW-1:H] : bm_q[H-1:0];
		pp = PW'(MW'(ah) * MW'(bh));
		case (cnt_q)
			2'd0: pp = pp;
			2'd3: pp = pp << (2 * H);
			default: pp = pp << H;
		endcase
		rnd  = acc_q + (PW'(1) << (FRAC_BITS - 1));
		mag  = rnd >> FRAC_BITS;
		lim  = (PW'(1) << (WORD_BITS - 1)) - PW'(!neg_q);
		smag = (mag > lim) ? lim : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[WORD_BITS-1] ? -ae : ae;
			bm_q  <= b[WORD_BITS-1] ? -be : be;
			neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp;
		end
		if (rnd_q)
			res_q <= neg_q ? -WORD_BITS'(smag) : WORD_BITS'(smag);
	end

	assign done = done_q;
	assign prod = res_q;

endmodule

FILE: hdl/vpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpw_div
// Reciprocal of w: round(2^(2F) / |w|) with the sign of w, saturated.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpw_div import vpw_pkg::*; #(
	parameter int WORD_BITS = VPW_WORD_BITS,
	parameter int FRAC_BITS = VPW_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] w,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] recip
);

	localparam int NB = ((2 * FRAC_BITS > WORD_BITS - 2) ? 2 * FRAC_BITS : WORD_BITS - 2) + 1;
	localparam int QW = (NB > WORD_BITS) ? NB : WORD_BITS;
	localparam int CW = $clog2(NB + 1);

	logic [WORD_BITS-1:0] uw_q;
	logic [WORD_BITS:0]   rem_q;
	logic [NB-1:0]        num_q, q_q;
	logic                 neg_q, busy_q, done_q;
	logic [CW-1:0]        cnt_q;

	logic [WORD_BITS-1:0] uw;
	logic [WORD_BITS:0]   t;
	logic                 ge;
	logic [QW-1:0]        qx, lim;

	always_comb begin
		uw  = w[WORD_BITS-1] ? -w : w;
		t   = {rem_q[WORD_BITS-1:0], num_q[NB-1]};
		ge  = t >= {1'b0, uw_q};
		qx  = QW'(q_q);
		lim = (QW'(1) << (WORD_BITS - 1)) - QW'(!neg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			uw_q  <= uw;
			neg_q <= w[WORD_BITS-1];
			rem_q <= '0;
			q_q   <= '0;
			num_q <= (NB'(1) << (2 * FRAC_BITS)) + NB'(uw >> 1);
		end else if (busy_q) begin
			rem_q <= ge ? (t - {1'b0, uw_q}) : t;
			q_q   <= {q_q[NB-2:0], ge};
			num_q <= num_q << 1;
		end
	end

	always_comb begin
		recip = (qx > lim) ? WORD_BITS'(lim) : WORD_BITS'(qx);
		if (neg_q)
			recip = -recip;
	end

	assign done = done_q;

endmodule

FILE: hdl/vertex_project_to_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_to_window_core
// Projects object-space points through modelview and projection matrices to
// viewport window coordinates in signed fixed point.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one coefficient. A project beat runs a fixed
// 42-step program over the coefficient store and a scratch store, one step
// at a time through a single shared multiplier: a multiply step passes
// through the RD, LAT, MULW and ACC states, an add step through RD, LAT and
// ACC, and the reciprocal of w comes from a serial restoring divider. The
// result sits in an output register, so the next beat is taken while it
// waits.
// ----------------------------------------------------------------------------
module vertex_project_to_window_core import vpw_pkg::*; #(
	parameter int FRAC_BITS = VPW_FRAC_BITS,
	parameter int WORD_BITS = VPW_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [135:0]         s_tdata,  // coef_index, coef_value, point_x, point_y, point_z
	input  logic                 s_tuser,  // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [95:0]          m_tdata,  // win_x, win_y, win_depth
	output logic                 m_tuser,  // valid_res
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata
);

	localparam int W  = WORD_BITS;
	localparam int AW = WORD_BITS + 3;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_LAT  = 3'd2;
	localparam logic [2:0] ST_MULW = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_DIVS = 3'd5;
	localparam logic [2:0] ST_DIVW = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			return W'(hi);
		else if (v < lo)
			return W'(lo);
		return W'(v);
	endfunction

	logic [2:0]      st_q;
	logic [PC_W-1:0] pc_q;
	logic [REG_W-1:0] ox_q, oy_q, vw_q, vh_q;
	logic [COEF_DEPTH-1:0] cvalid_q;
	logic            cval_q;
	logic signed [W-1:0] px_q, py_q, pz_q, rw_q, w_q, term_q;
	logic signed [W-1:0] wx_q, wy_q, wd_q;
	logic            ok_q;
	logic signed [AW-1:0] acc_q;
	logic            ov_q, ovr_q;
	logic [31:0]     ox32_q, oy32_q, od32_q;

	uop_t            op;
	logic            in_acc, load_we, scr_we, out_load;
	logic signed [W-1:0] crd, srd, va, vb, half, one, pixw, pixh, pixox, pixoy, sum_sat;
	logic signed [AW-1:0] acc_new;
	logic            mul_start, mul_done, div_start, div_done;
	logic signed [W-1:0] mul_res, div_res;

	assign op       = vpw_prog(pc_q);
	assign s_tready = (st_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign load_we  = in_acc && (s_tuser == MODE_LOAD);

	vpw_ram #(.WIDTH(W), .DEPTH(COEF_DEPTH)) u_coef (
		.clk   (clk),
		.we    (load_we),
		.waddr (s_tdata[4:0]),
		.wdata (sat_w(64'(signed'(s_tdata[36:5])))),
		.raddr (op.caddr),
		.rdata (crd)
	);

	vpw_ram #(.WIDTH(W), .DEPTH(SCR_DEPTH)) u_scr (
		.clk   (clk),
		.we    (scr_we),
		.waddr (op.dest),
		.wdata (sum_sat),
		.raddr (op.saddr),
		.rdata (srd)
	);

	vpw_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (va),
		.b      (vb),
		.done   (mul_done),
		.prod   (mul_res)
	);

	vpw_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.w      (w_q),
		.done   (div_done),
		.recip  (div_res)
	);

	always_comb begin
		half  = sat_w(64'sd1 <<< (FRAC_BITS - 1));
		one   = sat_w(64'sd1 <<< FRAC_BITS);
		pixw  = sat_w(signed'(64'(vw_q) << FRAC_BITS));
		pixh  = sat_w(signed'(64'(vh_q) << FRAC_BITS));
		pixox = sat_w(signed'(64'(ox_q) << FRAC_BITS));
		pixoy = sat_w(signed'(64'(oy_q) << FRAC_BITS));
	end

	function automatic logic signed [W-1:0] pick(input logic [3:0] s,
			input logic signed [W-1:0] c, input logic signed [W-1:0] sc,
			input logic signed [W-1:0] x, input logic signed [W-1:0] y,
			input logic signed [W-1:0] z, input logic signed [W-1:0] r,
			input logic signed [W-1:0] h, input logic signed [W-1:0] o,
			input logic signed [W-1:0] pw, input logic signed [W-1:0] ph,
			input logic signed [W-1:0] pox, input logic signed [W-1:0] poy);
		case (s)
			SRC_COEF:  return c;
			SRC_SCR:   return sc;
			SRC_PX:    return x;
			SRC_PY:    return y;
			SRC_PZ:    return z;
			SRC_RW:    return r;
			SRC_HALF:  return h;
			SRC_NHALF: return -h;
			SRC_ONE:   return o;
			SRC_PIXW:  return pw;
			SRC_PIXH:  return ph;
			SRC_PIXOX: return pox;
			SRC_PIXOY: return poy;
			default:   return '0;
		endcase
	endfunction

	always_comb begin
		va = pick(op.src_a, cval_q ? crd : '0, srd, px_q, py_q, pz_q, rw_q, half, one,
			pixw, pixh, pixox, pixoy);
		vb = pick(op.src_b, cval_q ? crd : '0, srd, px_q, py_q, pz_q, rw_q, half, one,
			pixw, pixh, pixox, pixoy);
		acc_new   = op.first ? AW'(term_q) : acc_q + AW'(term_q);
		sum_sat   = sat_w(64'(acc_new));
		scr_we    = (st_q == ST_ACC) && op.last;
		mul_start = (st_q == ST_LAT) && !op.is_add;
		div_start = (st_q == ST_DIVS) && (w_q != '0);
		out_load  = (st_q == ST_DONE) && (!ov_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			pc_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			vw_q     <= '0;
			vh_q     <= '0;
			cvalid_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ORIGIN_X: ox_q <= cfg_wdata;
					REG_ORIGIN_Y: oy_q <= cfg_wdata;
					REG_WIDTH:    vw_q <= cfg_wdata;
					REG_HEIGHT:   vh_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (load_we)
				cvalid_q[s_tdata[4:0]] <= 1'b1;
			if (out_load)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == MODE_PROJECT) begin
						pc_q <= '0;
						st_q <= ST_RD;
					end
				end
				ST_RD:   st_q <= ST_LAT;
				ST_LAT:  st_q <= op.is_add ? ST_ACC : ST_MULW;
				ST_MULW: if (mul_done) st_q <= ST_ACC;
				ST_ACC: begin
					pc_q <= pc_q + PC_W'(1);
					if (pc_q + PC_W'(1) == PC_DIV)
						st_q <= ST_DIVS;
					else if (pc_q + PC_W'(1) == PC_END)
						st_q <= ST_DONE;
					else
						st_q <= ST_RD;
				end
				ST_DIVS: st_q <= (w_q == '0) ? ST_DONE : ST_DIVW;
				ST_DIVW: if (div_done) st_q <= ST_RD;
				ST_DONE: if (out_load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cval_q <= cvalid_q[op.caddr];
		if (in_acc) begin
			px_q <= sat_w(64'(signed'(s_tdata[68:37])));
			py_q <= sat_w(64'(signed'(s_tdata[100:69])));
			pz_q <= sat_w(64'(signed'(s_tdata[132:101])));
			ok_q <= 1'b1;
		end
		if (st_q == ST_LAT && op.is_add)
			term_q <= va;
		if (st_q == ST_MULW && mul_done)
			term_q <= mul_res;
		if (st_q == ST_ACC) begin
			acc_q <= acc_new;
			if (op.last) begin
				if (op.dest == SCR_E2) w_q  <= sat_w(-64'(sum_sat));
				if (op.dest == SCR_WX) wx_q <= sum_sat;
				if (op.dest == SCR_WY) wy_q <= sum_sat;
				if (op.dest == SCR_WD) wd_q <= sum_sat;
			end
		end
		if (st_q == ST_DIVS && w_q == '0) begin
			ok_q <= 1'b0;
			wx_q <= '0;
			wy_q <= '0;
			wd_q <= '0;
		end
		if (div_done)
			rw_q <= div_res;
		if (out_load) begin
			ox32_q <= 32'(wx_q);
			oy32_q <= 32'(wy_q);
			od32_q <= 32'(wd_q);
			ovr_q  <= ok_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {od32_q, oy32_q, ox32_q};
	assign m_tuser  = ovr_q;

endmodule

FILE: tb/vertex_project_to_window_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_to_window_core_tb
// Self-checking bench for the fixed-point vertex projection core.
// ----------------------------------------------------------------------------
// Loads coefficients and projects points over the stream ports. A bit-exact
// fixed-point predictor computes the window coordinates of every accepted
// point but the directed culled rows. The bench first walks a short directed
// table, then runs several random phases under different viewport settings.
// Both sides idle at random but in one phase; one holds results off long.
// ----------------------------------------------------------------------------
module vertex_project_to_window_core_tb;
	import vpw_pkg::*;

	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  DRAIN_WAIT  = 400;
	localparam int  HOLD_CYCLES = 2000;
	localparam int  RAND_ITEMS  = 140;
	localparam int  NUM_PHASES  = 4;
	localparam longint ONE_Q    = 64'sd65536;
	localparam longint HALF_Q   = 64'sd32768;

	typedef struct packed {
		logic [31:0] win_x;
		logic [31:0] win_y;
		logic [31:0] win_depth;
		logic        valid_res;
	} win_t;

	typedef struct {
		logic        mode;
		logic [4:0]  idx;
		logic [31:0] val;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		bit          typed;
		win_t        want;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [135:0]  s_tdata;
	logic          s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [95:0]   m_tdata;
	logic          m_tuser;
	logic          cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;

	longint coef_mem [32];
	longint vp_ox, vp_oy, vp_w, vp_h;
	win_t   pending_wins [$];
	row_t   dir_rows [$];
	int     errors;
	int     cycles;
	int     n_loads, n_points, n_results, n_culled;
	bit     hold_req;
	bit     no_idle;

	vertex_project_to_window_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint sat_q(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint q_mul(input longint a, input longint b);
		bit neg;
		longint unsigned ua, ub, mag, lim;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? -a : a;
		ub  = (b < 0) ? -b : b;
		mag = (ua * ub + 64'd32768) >> 16;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		if (mag > lim)
			mag = lim;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint q_recip(input longint w);
		longint unsigned uw, q, lim;
		uw  = (w < 0) ? -w : w;
		lim = (w < 0) ? 64'd2147483648 : 64'd2147483647;
		q   = ((64'd1 << 32) + (uw >> 1)) / uw;
		if (q > lim)
			q = lim;
		return (w < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic win_t project_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		win_t   r;
		longint p [3];
		longint e [4];
		longint c [3];
		longint w, rw, t;
		p[0] = longint'($signed(x));
		p[1] = longint'($signed(y));
		p[2] = longint'($signed(z));
		for (int i = 0; i < 4; i++)
			e[i] = sat_q(q_mul(coef_mem[i], p[0]) + q_mul(coef_mem[4 + i], p[1])
				+ q_mul(coef_mem[8 + i], p[2]) + coef_mem[12 + i]);
		for (int i = 0; i < 3; i++)
			c[i] = sat_q(q_mul(coef_mem[16 + i], e[0]) + q_mul(coef_mem[20 + i], e[1])
				+ q_mul(coef_mem[24 + i], e[2]) + q_mul(coef_mem[28 + i], e[3]));
		w = sat_q(-e[2]);
		r = '0;
		if (w == 0)
			return r;
		rw = q_recip(w);
		t = sat_q(q_mul(q_mul(c[0], rw), HALF_Q) + HALF_Q);
		r.win_x = 32'(sat_q(q_mul(t, vp_w << 16) + (vp_ox << 16)));
		t = sat_q(q_mul(q_mul(c[1], rw), -HALF_Q) + HALF_Q);
		r.win_y = 32'(sat_q(q_mul(t, vp_h << 16) + (vp_oy << 16)));
		t = sat_q(ONE_Q + q_mul(c[2], rw));
		r.win_depth = 32'(q_mul(t, HALF_Q));
		r.valid_res = 1'b1;
		return r;
	endfunction

	function automatic row_t ld(input logic [4:0] idx, input logic [31:0] val);
		row_t r;
		r = '{default: '0};
		r.mode = MODE_LOAD;
		r.idx  = idx;
		r.val  = val;
		return r;
	endfunction

	function automatic row_t pt(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		row_t r;
		r = '{default: '0};
		r.mode = MODE_PROJECT;
		r.px = x;
		r.py = y;
		r.pz = z;
		return r;
	endfunction

	function automatic row_t pt_culled(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		row_t r;
		r = pt(x, y, z);
		r.typed = 1'b1;
		r.want  = '0;
		return r;
	endfunction

	task automatic write_viewport(input int ox, input int oy, input int w, input int h);
		int vals [4];
		logic [CFG_IDX_W-1:0] regs [4];
		vals = '{ox, oy, w, h};
		regs = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_WIDTH, REG_HEIGHT};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= REG_W'(vals[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		vp_ox = ox;
		vp_oy = oy;
		vp_w  = w;
		vp_h  = h;
	endtask

	task automatic send_beat(input row_t r);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.mode;
		s_tdata  <= {3'b000, r.pz, r.py, r.px, r.val, r.idx};
		do
			@(posedge clk);
		while (!s_tready);
		if (r.mode == MODE_LOAD) begin
			coef_mem[r.idx] = longint'($signed(r.val));
			n_loads++;
		end else begin
			pending_wins.push_back(r.typed ? r.want : project_point(r.px, r.py, r.pz));
			n_points++;
		end
	endtask

	task automatic drain();
		while (pending_wins.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 99) < 85)
			return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
		return $urandom;
	endfunction

	task automatic load_camera();
		for (int i = 0; i < 16; i++)
			send_beat(ld(5'(i), (i % 5 == 0) ? 32'h0001_0000
				: 32'($urandom_range(0, 32'h4000)) - 32'h2000));
		send_beat(ld(5'd14, -32'($urandom_range(32'h0001_0000, 32'h0008_0000))));
		for (int i = 16; i < 32; i++)
			send_beat(ld(5'(i), (i == 16 || i == 21 || i == 26)
				? 32'($urandom_range(32'h0000_8000, 32'h0003_0000))
				: 32'($urandom_range(0, 32'h2000)) - 32'h1000));
	endtask

	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 20)
			send_beat(ld(5'($urandom_range(0, 31)), ($urandom_range(0, 1) == 1) ? $urandom
				: 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000));
		else
			send_beat(pt(rand_coord(), rand_coord(), rand_coord()));
	endtask

	always @(posedge clk) begin
		if (arst_n)
			cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_wins.size());
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		win_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
			n_results++;
			if (!m_tuser)
				n_culled++;
			if (pending_wins.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h", $time, got);
			end else begin
				want = pending_wins.pop_front();
				if (got.win_x !== want.win_x) begin
					errors++;
					$display("%0t: win_x expected %h actual %h", $time, want.win_x, got.win_x);
				end
				if (got.win_y !== want.win_y) begin
					errors++;
					$display("%0t: win_y expected %h actual %h", $time, want.win_y, got.win_y);
				end
				if (got.win_depth !== want.win_depth) begin
					errors++;
					$display("%0t: win_depth expected %h actual %h", $time, want.win_depth,
						got.win_depth);
				end
				if (got.valid_res !== want.valid_res) begin
					errors++;
					$display("%0t: valid_res expected %b actual %b", $time, want.valid_res,
						got.valid_res);
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= 34);
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_LOAD;
		cfg_we    = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_wdata = '0;
		errors    = 0;
		cycles    = 0;
		n_loads   = 0;
		n_points  = 0;
		n_results = 0;
		n_culled  = 0;
		hold_req  = 1'b0;
		no_idle   = 1'b0;
		vp_ox = 0; vp_oy = 0; vp_w = 0; vp_h = 0;
		foreach (coef_mem[i])
			coef_mem[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_viewport(0, 0, 640, 480);
		dir_rows.push_back(pt_culled(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000));
		dir_rows.push_back(ld(5'd0, 32'h0001_0000));
		dir_rows.push_back(ld(5'd5, 32'h0001_0000));
		dir_rows.push_back(ld(5'd10, 32'h0001_0000));
		dir_rows.push_back(ld(5'd15, 32'h0001_0000));
		dir_rows.push_back(ld(5'd16, 32'h0001_0000));
		dir_rows.push_back(ld(5'd21, 32'h0001_0000));
		dir_rows.push_back(ld(5'd26, 32'h0001_0000));
		dir_rows.push_back(ld(5'd19, 32'h7FFF_FFFF));
		dir_rows.push_back(pt_culled(32'h0003_0000, 32'hFFFD_0000, 32'h0000_0000));
		dir_rows.push_back(pt(32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000));
		dir_rows.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000));
		dir_rows.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		dir_rows.push_back(pt(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF));
		dir_rows.push_back(ld(5'd14, 32'hFFFF_0000));
		dir_rows.push_back(pt(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
		dir_rows.push_back(pt(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
		dir_rows.push_back(ld(5'd28, 32'h8000_0000));
		dir_rows.push_back(ld(5'd31, 32'h7FFF_FFFF));
		dir_rows.push_back(ld(5'd23, 32'h1234_5678));
		dir_rows.push_back(ld(5'd27, 32'hEDCB_A987));
		dir_rows.push_back(pt(32'h0002_0000, 32'h0001_0000, 32'hFFFE_0000));
		dir_rows.push_back(ld(5'd12, 32'h7FFF_FFFF));
		dir_rows.push_back(pt(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		dir_rows.push_back(ld(5'd28, 32'h0000_0000));
		foreach (dir_rows[i])
			send_beat(dir_rows[i]);
		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: write_viewport(0, 0, 0, 0);
				1: write_viewport(16383, 16383, 16383, 16383);
				default: write_viewport($urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 16383), $urandom_range(0, 16383));
			endcase
			no_idle  = (ph == 2);
			hold_req = (ph == 1);
			load_camera();
			for (int n = 0; n < RAND_ITEMS; n++)
				random_item();
			@(negedge clk);
			s_tvalid <= 1'b0;
			drain();
		end

		$display("Covered %0d coefficient loads and %0d projected points (%0d culled)",
			n_loads, n_points, n_culled);
		$display("over five viewport settings, including zero and full-scale extremes");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
